@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define PNH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define PNH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/pnh_pkg.sv @@
// ----------------------------------------------------------------------------
// pnh_pkg
// Types, character codes, status codes and hash helpers for the path
// normalize and hash unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnh_pkg;

	localparam int unsigned DEF_MAX_PATH_BYTES = 256;
	localparam int unsigned DEF_MAX_PARTS      = 64;

	// result bus width, whole bytes
	localparam int unsigned TDATA_W = 104;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5a;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7a;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_LONG    = 3'd1,
		ST_ABOVE_ROOT  = 3'd2,
		ST_TOO_MANY    = 3'd3,
		ST_RESULT_LONG = 3'd4,
		ST_AT_LIMIT    = 3'd5
	} status_t;

	// open component: length saturates at three, dots = only '.' seen so far
	typedef struct packed {
		logic       active;
		logic [1:0] len;
		logic       dots;
	} token_t;

	// packed so that status lands in the lowest bits
	typedef struct packed {
		logic [7:0]  name_length;
		logic [7:0]  name_offset;
		logic [63:0] path_hash;
		logic [5:0]  component_count;
		logic [7:0]  norm_length;
		status_t     status;
	} result_t;

	typedef struct packed {
		logic out_valid;
		logic skid_valid;
	} buf_stat_t;

	// One FNV-1a step. The prime 2^40 + 0x1b3 is sparse: shift and add.
	function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] c);
		logic [63:0] x;
		x = h ^ {56'd0, c};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	localparam logic [63:0] ROOT_HASH = fnv_step(FNV_BASIS, CH_SLASH);

	function automatic logic is_letter(logic [7:0] c);
		return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
	endfunction

endpackage

`default_nettype wire

@@ design/pnh_ram.sv @@
// ----------------------------------------------------------------------------
// pnh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnh_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/pnh_core.sv @@
// ----------------------------------------------------------------------------
// pnh_core
// Per-byte path scanner: separator and drive handling, component tracking,
// FNV-1a update, snapshot stack control and final result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pnh_core #(
	parameter int unsigned MAX_PATH_BYTES = pnh_pkg::DEF_MAX_PATH_BYTES,
	parameter int unsigned MAX_PARTS      = pnh_pkg::DEF_MAX_PARTS,
	localparam int unsigned LW = $clog2(MAX_PATH_BYTES + 1),
	localparam int unsigned CW = $clog2(MAX_PARTS + 1),
	localparam int unsigned AW = $clog2(MAX_PARTS),
	localparam int unsigned DW = 64 + LW
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              st_we,
	output logic [AW-1:0]     st_waddr,
	output logic [DW-1:0]     st_wdata,
	output logic [AW-1:0]     st_raddr,
	input  logic [DW-1:0]     st_rdata,
	output logic              res_valid,
	output pnh_pkg::result_t  res
);

	localparam logic [LW-1:0] POS_LIMIT   = LW'(MAX_PATH_BYTES);
	localparam logic [LW-1:0] POS_LAST_OK = LW'(MAX_PATH_BYTES - 1);
	localparam logic [CW-1:0] CNT_LIMIT   = CW'(MAX_PARTS);

	// scan state
	logic [LW-1:0]     pos_q, pos_d;
	logic [63:0]       hash_q, hash_d;
	logic [63:0]       slash_q, slash_d;
	logic [LW-1:0]     len_q, len_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	pnh_pkg::token_t   tok_q, tok_d;
	pnh_pkg::status_t  err_q, err_d;
	logic              nul_q, nul_d;
	logic              drive_q, drive_d;

	// snapshot of the open component and of the component below it
	logic [63:0]       open_h_q, top_h_q;
	logic [LW-1:0]     open_l_q, top_l_q;

	logic              proc, live, is_sep, is_nul, revert, feed, absorb, start, sep_end;
	logic              fin, dot1, dot2, too_long, restart;
	logic [63:0]       base_h, mul_h, a_hash, snap_h, slash_src;
	logic [LW-1:0]     a_len, snap_l, noff;
	pnh_pkg::token_t   tok_abs, fin_tok;
	logic [63:0]       f_hash, f_top_h;
	logic [LW-1:0]     f_len, f_top_l;
	logic [CW-1:0]     f_cnt, rd_pre;
	pnh_pkg::status_t  f_err;

	always_comb begin
		proc    = in_valid && (pos_q < POS_LAST_OK);
		live    = !nul_q && (err_q == pnh_pkg::ST_OK);
		is_sep  = (in_byte == pnh_pkg::CH_SLASH) || (in_byte == pnh_pkg::CH_BSLASH);
		is_nul  = (in_byte == pnh_pkg::CH_NUL);
		// drive letter already taken as text: a colon right after it undoes it
		revert  = proc && (pos_q == LW'(1)) && drive_q && (in_byte == pnh_pkg::CH_COLON);
		feed    = proc && live && !revert;
		absorb  = feed && !is_sep && !is_nul;
		start   = absorb && !tok_q.active;
		sep_end = feed && (is_sep || is_nul) && tok_q.active;

		// token start hashes from the precomputed slash hash
		base_h = tok_q.active ? hash_q : slash_q;
		mul_h  = pnh_pkg::fnv_step(base_h, in_byte);

		tok_abs.active = 1'b1;
		if (start) begin
			tok_abs.len = 2'd1;
		end else if (tok_q.len == 2'd3) begin
			tok_abs.len = 2'd3;
		end else begin
			tok_abs.len = tok_q.len + 2'd1;
		end
		tok_abs.dots = (start || tok_q.dots) && (in_byte == pnh_pkg::CH_DOT);

		fin_tok = absorb ? tok_abs : tok_q;
		a_hash  = absorb ? mul_h : hash_q;
		a_len   = absorb ? (len_q + (start ? LW'(2) : LW'(1))) : len_q;

		fin  = sep_end || (in_valid && in_last && live && !revert && fin_tok.active);
		dot1 = fin_tok.dots && (fin_tok.len == 2'd1);
		dot2 = fin_tok.dots && (fin_tok.len == 2'd2);

		snap_h = start ? hash_q : open_h_q;
		snap_l = start ? len_q : open_l_q;

		f_hash    = a_hash;
		f_len     = a_len;
		f_cnt     = cnt_q;
		f_err     = err_q;
		f_top_h   = top_h_q;
		f_top_l   = top_l_q;
		slash_src = hash_q;
		if (fin) begin
			if (dot1) begin
				f_hash    = snap_h;
				f_len     = snap_l;
				slash_src = open_h_q;
			end else if (dot2) begin
				if (cnt_q == '0) begin
					f_err = pnh_pkg::ST_ABOVE_ROOT;
				end else begin
					f_cnt     = cnt_q - CW'(1);
					f_hash    = top_h_q;
					f_len     = top_l_q;
					f_top_h   = st_rdata[DW-1:LW];
					f_top_l   = st_rdata[LW-1:0];
					slash_src = top_h_q;
				end
			end else if (cnt_q >= CNT_LIMIT) begin
				f_err = pnh_pkg::ST_TOO_MANY;
			end else begin
				f_cnt   = cnt_q + CW'(1);
				f_top_h = snap_h;
				f_top_l = snap_l;
			end
		end

		too_long = pos_q >= POS_LAST_OK;
		restart  = (in_valid && in_last) || revert;

		// next state
		pos_d   = pos_q;
		hash_d  = hash_q;
		slash_d = slash_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		tok_d   = tok_q;
		err_d   = err_q;
		nul_d   = nul_q;
		drive_d = drive_q;
		if (in_valid) begin
			pos_d   = (pos_q < POS_LIMIT) ? pos_q + LW'(1) : pos_q;
			hash_d  = f_hash;
			len_d   = f_len;
			cnt_d   = f_cnt;
			err_d   = f_err;
			nul_d   = nul_q || (feed && is_nul);
			drive_d = proc && (pos_q == '0) && pnh_pkg::is_letter(in_byte);
			if (absorb) begin
				tok_d = tok_abs;
			end else if (sep_end) begin
				tok_d.active = 1'b0;
			end
			if (sep_end) begin
				slash_d = pnh_pkg::fnv_step(slash_src, pnh_pkg::CH_SLASH);
			end
		end
		if (restart) begin
			if (in_last) begin
				pos_d = '0;
			end
			hash_d  = pnh_pkg::FNV_BASIS;
			slash_d = pnh_pkg::ROOT_HASH;
			len_d   = '0;
			cnt_d   = '0;
			tok_d   = '0;
			err_d   = pnh_pkg::ST_OK;
			nul_d   = 1'b0;
			drive_d = 1'b0;
		end

		// stack: push snapshot at token start, keep reading two below the count
		st_we    = start && (cnt_q < CNT_LIMIT);
		st_waddr = cnt_q[AW-1:0];
		st_wdata = {hash_q, len_q};
		rd_pre   = cnt_d - CW'(2);
		st_raddr = rd_pre[AW-1:0];

		// result
		noff      = f_top_l + LW'(1);
		res_valid = in_valid && in_last;
		res       = '0;
		if (too_long) begin
			res.status = pnh_pkg::ST_TOO_LONG;
		end else if (f_err != pnh_pkg::ST_OK) begin
			res.status = f_err;
		end else if (f_cnt == '0) begin
			res.norm_length = 8'd1;
			res.path_hash   = pnh_pkg::ROOT_HASH;
		end else if (f_len >= POS_LIMIT) begin
			res.status = pnh_pkg::ST_RESULT_LONG;
		end else if (f_cnt >= CNT_LIMIT) begin
			res.status = pnh_pkg::ST_AT_LIMIT;
		end else begin
			res.norm_length     = 8'(f_len);
			res.component_count = 6'(f_cnt);
			res.path_hash       = f_hash;
			res.name_offset     = 8'(noff);
			res.name_length     = 8'(f_len - noff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hash_q  <= pnh_pkg::FNV_BASIS;
			slash_q <= pnh_pkg::ROOT_HASH;
			len_q   <= '0;
			cnt_q   <= '0;
			tok_q   <= '0;
			err_q   <= pnh_pkg::ST_OK;
			nul_q   <= 1'b0;
			drive_q <= 1'b0;
		end else begin
			pos_q   <= pos_d;
			hash_q  <= hash_d;
			slash_q <= slash_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			tok_q   <= tok_d;
			err_q   <= err_d;
			nul_q   <= nul_d;
			drive_q <= drive_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			open_h_q <= hash_q;
			open_l_q <= len_q;
		end
		if (in_valid) begin
			top_h_q <= f_top_h;
			top_l_q <= f_top_l;
		end
	end

	`PNH_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_LIMIT, "component count beyond limit")
	`PNH_ASSERT_NEXT(a_clear_after_result, in_valid && in_last,
		(cnt_q == '0) && !tok_q.active && (pos_q == '0) && (err_q == pnh_pkg::ST_OK),
		"scan state not cleared after result")
	`PNH_ASSERT_NEXT(a_err_sticky, (err_q != pnh_pkg::ST_OK) && in_valid && !in_last,
		err_q == $past(err_q), "error code changed mid path")
	`PNH_ASSERT_NOW(a_tok_len, tok_q.active, len_q > open_l_q,
		"open component shorter than its snapshot")

endmodule

`default_nettype wire

@@ design/pnh_outbuf.sv @@
// ----------------------------------------------------------------------------
// pnh_outbuf
// Result register with a skid entry behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pnh_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  pnh_pkg::result_t    res,
	output logic                out_valid,
	input  logic                out_ready,
	output pnh_pkg::result_t    out_res,
	output pnh_pkg::buf_stat_t  stat
);

	logic              out_valid_q, skid_valid_q, stall;
	pnh_pkg::result_t  out_q, skid_q;

	assign stall = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (stall) begin
			if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stall) begin
			if (res_valid) begin
				skid_q <= res;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_res         = out_q;
	assign stat.out_valid  = out_valid_q;
	assign stat.skid_valid = skid_valid_q;

	`PNH_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds item with empty output")
	`PNH_ASSERT_NOW(a_no_overrun, res_valid, !skid_valid_q, "result arrived with skid full")
	`PNH_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready, !skid_valid_q || out_valid_q,
		"skid not moving forward")

endmodule

`default_nettype wire

@@ design/path_normalize_and_hash_unit.sv @@
// ----------------------------------------------------------------------------
// path_normalize_and_hash_unit
// Streaming path canonicalizer with a 64-bit FNV-1a hash of the result.
// ----------------------------------------------------------------------------
// The unit takes one raw path byte per cycle and, at the byte marked tlast,
// delivers one result item: status, normalized length, component count,
// FNV-1a 64 hash of the rebuilt "/a/b" text, and offset and length of the
// last component. Backslash counts as slash, a leading "X:" drive prefix is
// dropped, empty and "." components vanish and ".." pops one component.
// Throughput is one byte per cycle while s_tready is high, paths back to back
// with no gap; the figure is set by the per-byte hash step (one sparse FNV
// multiply) and by the snapshot stack, a RAM written at each component start
// and read continuously two entries below the count so that a pop finds the
// next snapshot already waiting. From the last byte the result passes the
// input register, then the result register, to m_tvalid. s_tready drops when
// the skid entry holds a result, or when a final byte in the input register
// meets a full output register. The stack needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module path_normalize_and_hash_unit #(
	parameter int unsigned MAX_PATH_BYTES = pnh_pkg::DEF_MAX_PATH_BYTES,
	parameter int unsigned MAX_PARTS      = pnh_pkg::DEF_MAX_PARTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] path_byte
	input  logic                        s_tlast,   // is_last
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [2:0] status, [10:3] norm_length, [16:11] component_count,
	// [80:17] path_hash, [88:81] name_offset, [96:89] name_length, rest zero
	output logic [pnh_pkg::TDATA_W-1:0] m_tdata
);

	localparam int unsigned LW = $clog2(MAX_PATH_BYTES + 1);
	localparam int unsigned AW = $clog2(MAX_PARTS);
	localparam int unsigned DW = 64 + LW;

	// input register
	logic        in_valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// snapshot stack port
	logic          st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [DW-1:0] st_wdata, st_rdata;

	logic                res_valid, out_valid;
	pnh_pkg::result_t    res, out_res;
	pnh_pkg::buf_stat_t  buf_stat;

	// Hold off new bytes when the skid entry is taken, or when a final byte
	// in the input register is about to land on an occupied output register:
	// that result may take the skid entry, so nothing more may follow it yet.
	assign s_tready = !buf_stat.skid_valid && !(in_valid_s1 && last_s1 && buf_stat.out_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else begin
			in_valid_s1 <= s_tvalid && s_tready;
		end
	end

	// payload: capture on accept only
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// scanner: all per-byte work between the input and result registers
	pnh_core #(
		.MAX_PATH_BYTES (MAX_PATH_BYTES),
		.MAX_PARTS      (MAX_PARTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid_s1),
		.in_byte   (byte_s1),
		.in_last   (last_s1),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_wdata  (st_wdata),
		.st_raddr  (st_raddr),
		.st_rdata  (st_rdata),
		.res_valid (res_valid),
		.res       (res)
	);

	// hash and length snapshots, one per open component
	pnh_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_PARTS)
	) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// result register and skid entry
	pnh_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.stat      (buf_stat)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = pnh_pkg::TDATA_W'(out_res);

endmodule

`default_nettype wire
